/* sv/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define KPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds across reset
`define KPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/kpq_pkg.sv */
package kpq_pkg;

  // key vector and counter widths
  localparam int KEY_COUNT = 10;
  localparam int KEY_W     = 10;
  localparam int RPT_W     = 6;
  localparam int HOLD_W    = 10;
  localparam int GROUPS    = 3;
  localparam int HOLDERS   = 2;

  // stream widths
  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 72;
  localparam int CFG_IDX_W = 3;

  // keys above the pad size are dropped
  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((1 << KEY_COUNT) - 1);

  // key masks
  localparam logic [KEY_W-1:0] KEY_B    = 10'h002;
  localparam logic [KEY_W-1:0] KEY_R    = 10'h100;
  localparam logic [KEY_W-1:0] KEY_L    = 10'h200;
  localparam logic [KEY_W-1:0] KEY_DPAD = 10'h0F0;

  localparam logic [HOLD_W-1:0] HOLD_AFTER_RESET = 10'd999;

  // register reset values
  localparam logic [RPT_W-1:0]  REPEAT_CAP_RST  = 6'd50;
  localparam logic [RPT_W-1:0]  REPEAT_FIRE_RST = 6'd48;
  localparam logic [RPT_W-1:0]  REPEAT_LOAD_RST = 6'd43;
  localparam logic [HOLD_W-1:0] SHORT_LIMIT_RST = 10'd12;
  localparam logic [HOLD_W-1:0] HOLD_CAP_RST    = 10'd100;

  // item kinds
  typedef enum logic [1:0] {
    OP_FRAME     = 2'd0,
    OP_LOAD      = 2'd1,
    OP_RESET_RPT = 2'd2,
    OP_UNPRESS   = 2'd3
  } op_t;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPEAT_CAP     = 3'd0,
    REG_REPEAT_FIRE_AT = 3'd1,
    REG_REPEAT_RELOAD  = 3'd2,
    REG_SHORT_LIMIT    = 3'd3,
    REG_HOLD_CAP       = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [RPT_W-1:0]  repeat_cap;
    logic [RPT_W-1:0]  repeat_fire_at;
    logic [RPT_W-1:0]  repeat_reload;
    logic [HOLD_W-1:0] short_limit;
    logic [HOLD_W-1:0] hold_cap;
  } cfg_t;

  // per-item strobes from the top level to the timer units
  typedef struct packed {
    logic frame;
    logic reset_rpt;
  } step_t;

endpackage

/* sv/button_repeat_shortpress_qualifier_unit.sv */
// Keypad qualifier for a 10-key pad. Each request on the s_ side is one event:
// a frame sample with the held keys, a buffer load, a repeat-timer reset or an
// unpress. For each request one result leaves on the m_ side with this frame's
// newly pressed, auto-repeat and short-press keys and the visible snapshot
// after the event. The block takes one request per cycle unless a stalled result
// (m_tready low) holds it back; a request is held in the input register, the state
// update and result are formed from it combinationally and the result register
// presents the result. The user must write registers through cfg_we only while
// no request is in flight; the block itself does not enforce it.
module button_repeat_shortpress_qualifier_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [kpq_pkg::S_TDATA_W-1:0]     s_tdata,   // keys_down[9:0], zero pad
  input  logic [kpq_pkg::S_TUSER_W-1:0]     s_tuser,   // op[1:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [kpq_pkg::M_TDATA_W-1:0]     m_tdata,   // frame_pressed, frame_repeated,
                                                       // frame_short, shown_held,
                                                       // shown_pressed, shown_repeated,
                                                       // shown_short, zero pad
  input  logic                              cfg_we,
  input  logic [kpq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kpq_pkg::HOLD_W-1:0]        cfg_wdata
);

  localparam int KW = kpq_pkg::KEY_W;

  kpq_pkg::cfg_t   cfg;
  kpq_pkg::step_t  step;
  kpq_pkg::op_t    in_op;
  logic            in_valid;
  logic [KW-1:0]   in_keys;
  logic            advance;

  logic [KW-1:0]   last_keys, held, frame_pressed, frame_repeated, frame_short;
  logic [KW-1:0]   buffer_bits [4];
  logic [KW-1:0]   buffer_next [4];
  logic [KW-1:0]   visible_bits [4];
  logic [KW-1:0]   visible_next [4];
  logic [KW-1:0]   rpt_fired [kpq_pkg::GROUPS];
  logic [kpq_pkg::HOLDERS-1:0] hold_hit;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_cap     <= kpq_pkg::REPEAT_CAP_RST;
      cfg.repeat_fire_at <= kpq_pkg::REPEAT_FIRE_RST;
      cfg.repeat_reload  <= kpq_pkg::REPEAT_LOAD_RST;
      cfg.short_limit    <= kpq_pkg::SHORT_LIMIT_RST;
      cfg.hold_cap       <= kpq_pkg::HOLD_CAP_RST;
    end else if (cfg_we) begin
      case (kpq_pkg::reg_idx_t'(cfg_index))
        kpq_pkg::REG_REPEAT_CAP:     cfg.repeat_cap     <= cfg_wdata[kpq_pkg::RPT_W-1:0];
        kpq_pkg::REG_REPEAT_FIRE_AT: cfg.repeat_fire_at <= cfg_wdata[kpq_pkg::RPT_W-1:0];
        kpq_pkg::REG_REPEAT_RELOAD:  cfg.repeat_reload  <= cfg_wdata[kpq_pkg::RPT_W-1:0];
        kpq_pkg::REG_SHORT_LIMIT:    cfg.short_limit    <= cfg_wdata;
        kpq_pkg::REG_HOLD_CAP:       cfg.hold_cap       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register, refilled in the cycle it empties
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op   <= kpq_pkg::op_t'(s_tuser);
      in_keys <= s_tdata[KW-1:0];
    end
  end

  // per-item strobes
  always_comb begin
    step.frame     = advance && (in_op == kpq_pkg::OP_FRAME);
    step.reset_rpt = advance && (in_op == kpq_pkg::OP_RESET_RPT);
  end

  // edge detect
  assign held          = in_keys & kpq_pkg::KEY_MASK;
  assign frame_pressed = step.frame ? ((last_keys ^ held) & held) : '0;

  // auto-repeat groups: direction pad, L, R
  kpq_repeat u_rpt_dpad (
    .clk(clk), .rst(rst), .step(step), .cfg(cfg), .group_mask(kpq_pkg::KEY_DPAD),
    .held(held), .pressed(frame_pressed), .fired(rpt_fired[0])
  );
  kpq_repeat u_rpt_l (
    .clk(clk), .rst(rst), .step(step), .cfg(cfg), .group_mask(kpq_pkg::KEY_L),
    .held(held), .pressed(frame_pressed), .fired(rpt_fired[1])
  );
  kpq_repeat u_rpt_r (
    .clk(clk), .rst(rst), .step(step), .cfg(cfg), .group_mask(kpq_pkg::KEY_R),
    .held(held), .pressed(frame_pressed), .fired(rpt_fired[2])
  );
  assign frame_repeated = rpt_fired[0] | rpt_fired[1] | rpt_fired[2];

  // short press timers for B and R
  kpq_hold u_hold_b (
    .clk(clk), .rst(rst), .step(step), .cfg(cfg),
    .key_held((held & kpq_pkg::KEY_B) != '0), .short_hit(hold_hit[0])
  );
  kpq_hold u_hold_r (
    .clk(clk), .rst(rst), .step(step), .cfg(cfg),
    .key_held((held & kpq_pkg::KEY_R) != '0), .short_hit(hold_hit[1])
  );
  assign frame_short = (hold_hit[0] ? kpq_pkg::KEY_B : '0) | (hold_hit[1] ? kpq_pkg::KEY_R : '0);

  // buffer and snapshot update
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      buffer_next[i]  = buffer_bits[i];
      visible_next[i] = visible_bits[i];
    end
    case (in_op)
      kpq_pkg::OP_FRAME: begin
        buffer_next[0] = buffer_bits[0] | held;
        buffer_next[1] = buffer_bits[1] | frame_pressed;
        buffer_next[2] = buffer_bits[2] | frame_repeated;
        buffer_next[3] = buffer_bits[3] | frame_short;
      end
      kpq_pkg::OP_LOAD: begin
        for (int i = 0; i < 4; i++) begin
          visible_next[i] = buffer_bits[i];
          buffer_next[i]  = '0;
        end
      end
      kpq_pkg::OP_RESET_RPT: begin
        visible_next[2] = '0;
      end
      kpq_pkg::OP_UNPRESS: begin
        visible_next[1] = '0;
        buffer_next[1]  = '0;
      end
      default: ;
    endcase
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_keys <= '0;
      for (int i = 0; i < 4; i++) begin
        buffer_bits[i]  <= '0;
        visible_bits[i] <= '0;
      end
    end else if (advance) begin
      if (in_op == kpq_pkg::OP_FRAME) begin
        last_keys <= held;
      end
      for (int i = 0; i < 4; i++) begin
        buffer_bits[i]  <= buffer_next[i];
        visible_bits[i] <= visible_next[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {2'b00, visible_next[3], visible_next[2], visible_next[1], visible_next[0],
                  frame_short, frame_repeated, frame_pressed};
    end
  end

endmodule

/* sv/kpq_repeat.sv */
module kpq_repeat (
  input  logic                       clk,
  input  logic                       rst,
  input  kpq_pkg::step_t             step,
  input  kpq_pkg::cfg_t              cfg,
  input  logic [kpq_pkg::KEY_W-1:0]  group_mask,
  input  logic [kpq_pkg::KEY_W-1:0]  held,
  input  logic [kpq_pkg::KEY_W-1:0]  pressed,
  output logic [kpq_pkg::KEY_W-1:0]  fired
);

  logic [kpq_pkg::KEY_W-1:0] group_keys, group_keys_next, group_hit;
  logic [kpq_pkg::RPT_W-1:0] repeat_count, repeat_count_next, count_hit;

  // latch or count the group pattern, then decide the fire
  always_comb begin
    if (held != '0) begin
      if (group_keys == (held & group_mask)) begin
        group_hit = group_keys;
        count_hit = (repeat_count < cfg.repeat_cap) ? repeat_count + 1'b1 : repeat_count;
      end else begin
        group_hit = held & group_mask;
        count_hit = kpq_pkg::RPT_W'(1);
      end
    end else begin
      group_hit = '0;
      count_hit = '0;
    end

    fired = '0;
    repeat_count_next = count_hit;
    if (count_hit == kpq_pkg::RPT_W'(1)) begin
      fired = group_hit | pressed;
    end else if (count_hit == cfg.repeat_fire_at) begin
      fired = group_hit | pressed;
      repeat_count_next = cfg.repeat_reload;
    end
    group_keys_next = group_hit;
    if (!step.frame) begin
      fired = '0;
    end
  end

  // timer state
  always_ff @(posedge clk) begin
    if (rst || step.reset_rpt) begin
      group_keys   <= '0;
      repeat_count <= '0;
    end else if (step.frame) begin
      group_keys   <= group_keys_next;
      repeat_count <= repeat_count_next;
    end
  end

endmodule

/* sv/kpq_hold.sv */
module kpq_hold (
  input  logic                       clk,
  input  logic                       rst,
  input  kpq_pkg::step_t             step,
  input  kpq_pkg::cfg_t              cfg,
  input  logic                       key_held,
  output logic                       short_hit
);

  logic [kpq_pkg::HOLD_W-1:0] hold_count, hold_count_next;

  // count while held, judge the count on release
  always_comb begin
    short_hit = 1'b0;
    if (key_held) begin
      hold_count_next = (hold_count < cfg.hold_cap) ? hold_count + 1'b1 : hold_count;
    end else begin
      short_hit = step.frame && (hold_count > kpq_pkg::HOLD_W'(1))
                  && (hold_count < cfg.short_limit);
      hold_count_next = '0;
    end
  end

  // hold timer
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count <= '0;
    end else if (step.reset_rpt) begin
      hold_count <= kpq_pkg::HOLD_AFTER_RESET;
    end else if (step.frame) begin
      hold_count <= hold_count_next;
    end
  end

endmodule

/* sv/kpq_checker.sv */
`include "assert_macros.svh"

module kpq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [kpq_pkg::M_TDATA_W-1:0]     m_tdata
);

  // no result right after reset
  `KPQ_ASSERT_ALWAYS(a_idle_after_rst, rst |=> !m_tvalid, "result valid after reset")

  // a stalled result holds
  `KPQ_ASSERT(a_hold_stall, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stall lost")

  // short presses only come from B and R
  `KPQ_ASSERT(a_short_keys, m_tvalid |-> (m_tdata[29:20] & ~(kpq_pkg::KEY_B | kpq_pkg::KEY_R)) == '0, "short on bad key")

  // shown pressed keys are always shown held keys too
  `KPQ_ASSERT(a_pressed_held, m_tvalid |-> (m_tdata[49:40] & ~m_tdata[39:30]) == '0, "pressed not held")

endmodule

bind button_repeat_shortpress_qualifier_unit kpq_checker u_kpq_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
